// ----- hw/rtl/plotter_relative_move_encoder_defines.svh -----
// ----------------------------------------------------------------------------
// Plotter relative move encoder - assertion macros
// Shared assertion forms, clocked on clk and quiet while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PLOTTER_RELATIVE_MOVE_ENCODER_DEFINES_SVH
`define PLOTTER_RELATIVE_MOVE_ENCODER_DEFINES_SVH

// Same-cycle implication
`define PRME_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define PRME_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/prme_pkg.sv -----
// ----------------------------------------------------------------------------
// prme_pkg
// Types, codes and helpers shared by the relative move encoder modules.
// ----------------------------------------------------------------------------
package prme_pkg;

    // Terminal command and address codes
    localparam logic [7:0] CODE_DOUBLE = 8'o010;
    localparam logic [7:0] CODE_ADDR   = 8'o100;
    localparam logic [7:0] CODE_COM    = 8'o060;
    localparam logic [7:0] CODE_FULLX  = 8'o070;
    localparam logic [7:0] CODE_FULLY  = 8'o007;
    localparam logic [3:0] SINGLE_UNITS = 4'd7;
    localparam logic [8:0] COUNT_MAX   = 9'd511;

    // Configuration register indexes
    localparam logic [1:0] CFG_PEN_UP = 2'd0;
    localparam logic [1:0] CFG_ESCAPE = 2'd1;
    localparam logic [1:0] CFG_ENTER  = 2'd2;
    localparam logic [1:0] CFG_EXIT   = 2'd3;

    // Configuration reset values
    localparam logic [7:0] RST_PEN_UP = 8'd4;
    localparam logic [7:0] RST_ESCAPE = 8'd27;
    localparam logic [7:0] RST_ENTER  = 8'd3;
    localparam logic [7:0] RST_EXIT   = 8'd4;

    // Move queue depth
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;

    typedef struct packed {
        logic [7:0] pen_up_bits;
        logic [7:0] escape_byte;
        logic [7:0] enter_plot_byte;
        logic [7:0] exit_plot_byte;
    } cfg_t;

    // One classified move, handed from front to back
    typedef struct packed {
        logic       sign_x;
        logic       sign_y;
        logic       diag_en;
        logic [8:0] diag_cnt;
        logic       run_en;
        logic       run_x;
        logic [8:0] run_cnt;
        logic       single_x;
        logic       single_y;
        logic       rem_en;
        logic [2:0] rem_x;
        logic [2:0] rem_y;
    } move_t;

    // Clamp a step count to the repeat count range
    function automatic logic [8:0] sat_count(input logic [15:0] v);
        logic [8:0] r;
        r = (v > {7'd0, COUNT_MAX}) ? COUNT_MAX : v[8:0];
        return r;
    endfunction

endpackage

// ----- hw/rtl/prme_front.sv -----
// ----------------------------------------------------------------------------
// prme_front
// Accepts targets, tracks the pen, splits each move into step runs.
// ----------------------------------------------------------------------------
module prme_front
    import prme_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int STEP_UNITS = 7
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [COORD_BITS-1:0] target_x,
    input  logic [COORD_BITS-1:0] target_y,
    input  logic                  q_full,
    output logic                  push,
    output move_t                 entry
);

    localparam int DIV = 2 * STEP_UNITS;
    localparam int CB  = COORD_BITS;
    localparam logic [CB-1:0] RECIP = CB'((1 << CB) / DIV);
    localparam logic [CB-1:0] DIV_C = CB'(DIV);

    logic          adv;
    logic          accept;
    logic          same;
    logic [CB:0]   dx;
    logic [CB:0]   dy;

    logic [CB-1:0] pen_x_reg;
    logic [CB-1:0] pen_y_reg;

    logic          v1_reg;
    logic          sx1_reg;
    logic          sy1_reg;
    logic [CB-1:0] ax1_reg;
    logic [CB-1:0] ay1_reg;

    logic            v2_reg;
    logic            sx2_reg;
    logic            sy2_reg;
    logic [CB-1:0]   ax2_reg;
    logic [CB-1:0]   ay2_reg;
    logic [2*CB-1:0] px2_reg;
    logic [2*CB-1:0] py2_reg;

    logic          v3_reg;
    logic          sx3_reg;
    logic          sy3_reg;
    logic [CB-1:0] qx3_reg;
    logic [CB-1:0] qy3_reg;
    logic [3:0]    rx3_reg;
    logic [3:0]    ry3_reg;

    logic [CB-1:0] qx0;
    logic [CB-1:0] qy0;
    logic [CB-1:0] rx0;
    logic [CB-1:0] ry0;
    logic          fix_x;
    logic          fix_y;

    logic [15:0] qx16;
    logic [15:0] qy16;
    logic [15:0] pts;
    logic [15:0] run;
    logic [3:0]  remx;
    logic [3:0]  remy;
    logic        sgl_x;
    logic        sgl_y;

    // Stall the whole pipe while a finished move waits on a full queue
    assign adv      = !(v3_reg && q_full);
    assign in_ready = adv;
    assign accept   = in_valid && adv;
    assign push     = v3_reg && adv;

    // Signed deltas against the current pen position
    assign same = (target_x == pen_x_reg) && (target_y == pen_y_reg);
    assign dx   = {1'b0, target_x} - {1'b0, pen_x_reg};
    assign dy   = {1'b0, target_y} - {1'b0, pen_y_reg};

    // Quotient estimate from the reciprocal product, then one correction step
    assign qx0   = px2_reg[2*CB-1:CB];
    assign qy0   = py2_reg[2*CB-1:CB];
    assign rx0   = ax2_reg - CB'(qx0 * DIV_C);
    assign ry0   = ay2_reg - CB'(qy0 * DIV_C);
    assign fix_x = (rx0 >= DIV_C);
    assign fix_y = (ry0 >= DIV_C);

    // Track pen position and run the three front stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                pen_x_reg <= target_x;
                pen_y_reg <= target_y;
            end
            if (adv)
            begin
                v1_reg <= accept && !same;
                v2_reg <= v1_reg;
                v3_reg <= v2_reg;
            end
        end
    end

    // Stage payloads: magnitude, reciprocal product, corrected quotient
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sx1_reg <= dx[CB];
            sy1_reg <= dy[CB];
            ax1_reg <= dx[CB] ? CB'(-dx) : dx[CB-1:0];
            ay1_reg <= dy[CB] ? CB'(-dy) : dy[CB-1:0];

            sx2_reg <= sx1_reg;
            sy2_reg <= sy1_reg;
            ax2_reg <= ax1_reg;
            ay2_reg <= ay1_reg;
            px2_reg <= ax1_reg * RECIP;
            py2_reg <= ay1_reg * RECIP;

            sx3_reg <= sx2_reg;
            sy3_reg <= sy2_reg;
            qx3_reg <= fix_x ? qx0 + CB'(1) : qx0;
            qy3_reg <= fix_y ? qy0 + CB'(1) : qy0;
            rx3_reg <= fix_x ? 4'(rx0 - DIV_C) : rx0[3:0];
            ry3_reg <= fix_y ? 4'(ry0 - DIV_C) : ry0[3:0];
        end
    end

    // Classify the move into diagonal run, straight run, single and remainder
    always_comb
    begin
        qx16  = 16'(qx3_reg);
        qy16  = 16'(qy3_reg);
        pts   = (qx16 < qy16) ? qx16 : qy16;
        run   = (qx16 > qy16) ? qx16 - qy16 : qy16 - qx16;
        sgl_x = (rx3_reg > SINGLE_UNITS);
        sgl_y = (ry3_reg > SINGLE_UNITS);
        remx  = sgl_x ? rx3_reg - SINGLE_UNITS : rx3_reg;
        remy  = sgl_y ? ry3_reg - SINGLE_UNITS : ry3_reg;

        entry.sign_x   = sx3_reg;
        entry.sign_y   = sy3_reg;
        entry.diag_en  = (pts != 16'd0);
        entry.diag_cnt = sat_count(pts);
        entry.run_en   = (qx16 != qy16);
        entry.run_x    = (qx16 > qy16);
        entry.run_cnt  = sat_count(run);
        entry.single_x = sgl_x;
        entry.single_y = sgl_y;
        entry.rem_en   = (remx != 4'd0) || (remy != 4'd0);
        entry.rem_x    = remx[2:0];
        entry.rem_y    = remy[2:0];
    end

endmodule

// ----- hw/rtl/prme_queue.sv -----
// ----------------------------------------------------------------------------
// prme_queue
// Short queue of classified moves between front and back.
// ----------------------------------------------------------------------------
module prme_queue
    import prme_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  move_t push_data,
    input  logic  pop,
    output move_t head,
    output logic  empty,
    output logic  full
);

`include "plotter_relative_move_encoder_defines.svh"

    move_t                slot_reg [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QPTR_BITS:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (QPTR_BITS+1)'(QUEUE_DEPTH));
    assign head  = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Store the pushed move
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    `PRME_ASSERT_IMP(a_no_push_full, push, !full, "move pushed into full queue")
    `PRME_ASSERT_IMP(a_no_pop_empty, pop, !empty, "move popped from empty queue")
    `PRME_ASSERT_NXT(a_count_up, push && !pop, count_reg == $past(count_reg) + 1'b1,
        "queue occupancy did not grow on push")

endmodule

// ----- hw/rtl/prme_back.sv -----
// ----------------------------------------------------------------------------
// prme_back
// Walks the byte sequence of the head move, one result beat per cycle while the result port is ready.
// ----------------------------------------------------------------------------
module prme_back
    import prme_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_t       cfg,
    input  move_t      head,
    input  logic       empty,
    output logic       pop,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] out_byte,
    output logic [8:0] out_count,
    output logic       out_last
);

`include "plotter_relative_move_encoder_defines.svh"

    typedef enum logic [3:0] {
        ST_ESC,
        ST_ENTER,
        ST_DIAG_CMD,
        ST_DIAG_ADDR,
        ST_RUN_CMD,
        ST_RUN_ADDR,
        ST_SGL_CMD,
        ST_SGL_ADDR,
        ST_REM_CMD,
        ST_REM_ADDR,
        ST_EXIT1_ESC,
        ST_EXIT1_CODE,
        ST_EXIT2_ESC,
        ST_EXIT2_CODE
    } step_t;

    step_t      step_reg;
    step_t      step_next;
    step_t      after_diag;
    step_t      after_run;
    step_t      after_sgl;
    logic       out_valid_reg;
    logic [7:0] out_byte_reg;
    logic [8:0] out_count_reg;
    logic       out_last_reg;

    logic       load;
    logic       emit;
    logic [7:0] cmd;
    logic [7:0] byte_next;
    logic [8:0] count_next;

    // Refill the output register when empty or drained this cycle
    assign load = !out_valid_reg || out_ready;
    assign emit = load && !empty;
    assign pop  = emit && (step_reg == ST_EXIT2_CODE);

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_count = out_count_reg;
    assign out_last  = out_last_reg;

    assign cmd = CODE_COM | cfg.pen_up_bits | {6'd0, head.sign_x, head.sign_y};

    // Skip the parts of the move that are absent
    always_comb
    begin
        after_sgl  = head.rem_en ? ST_REM_CMD : ST_EXIT1_ESC;
        after_run  = (head.single_x || head.single_y) ? ST_SGL_CMD : after_sgl;
        after_diag = head.run_en ? ST_RUN_CMD : after_run;

        case (step_reg)
            ST_ESC:        step_next = ST_ENTER;
            ST_ENTER:      step_next = head.diag_en ? ST_DIAG_CMD : after_diag;
            ST_DIAG_CMD:   step_next = ST_DIAG_ADDR;
            ST_DIAG_ADDR:  step_next = after_diag;
            ST_RUN_CMD:    step_next = ST_RUN_ADDR;
            ST_RUN_ADDR:   step_next = after_run;
            ST_SGL_CMD:    step_next = ST_SGL_ADDR;
            ST_SGL_ADDR:   step_next = after_sgl;
            ST_REM_CMD:    step_next = ST_REM_ADDR;
            ST_REM_ADDR:   step_next = ST_EXIT1_ESC;
            ST_EXIT1_ESC:  step_next = ST_EXIT1_CODE;
            ST_EXIT1_CODE: step_next = ST_EXIT2_ESC;
            ST_EXIT2_ESC:  step_next = ST_EXIT2_CODE;
            ST_EXIT2_CODE: step_next = ST_ESC;
            default:       step_next = ST_ESC;
        endcase
    end

    // Byte and repeat count for the current step
    always_comb
    begin
        count_next = 9'd1;
        case (step_reg)
            ST_ESC:       byte_next = cfg.escape_byte;
            ST_ENTER:     byte_next = cfg.enter_plot_byte;
            ST_DIAG_CMD:  byte_next = cmd | CODE_DOUBLE;
            ST_DIAG_ADDR:
            begin
                byte_next  = CODE_ADDR | CODE_FULLX | CODE_FULLY;
                count_next = head.diag_cnt;
            end
            ST_RUN_CMD:   byte_next = cmd | CODE_DOUBLE;
            ST_RUN_ADDR:
            begin
                byte_next  = CODE_ADDR | (head.run_x ? CODE_FULLX : CODE_FULLY);
                count_next = head.run_cnt;
            end
            ST_SGL_CMD:   byte_next = cmd;
            ST_SGL_ADDR:
            begin
                byte_next = CODE_ADDR | (head.single_x ? CODE_FULLX : 8'd0)
                            | (head.single_y ? CODE_FULLY : 8'd0);
            end
            ST_REM_CMD:   byte_next = cmd;
            ST_REM_ADDR:  byte_next = CODE_ADDR | {2'b00, head.rem_x, head.rem_y};
            ST_EXIT1_ESC: byte_next = cfg.escape_byte;
            ST_EXIT2_ESC: byte_next = cfg.escape_byte;
            default:      byte_next = cfg.exit_plot_byte;
        endcase
    end

    // Hold the step and the output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= ST_ESC;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
            out_count_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else if (emit)
        begin
            step_reg      <= step_next;
            out_valid_reg <= 1'b1;
            out_byte_reg  <= byte_next;
            out_count_reg <= count_next;
            out_last_reg  <= (step_reg == ST_EXIT2_CODE);
        end
        else if (load)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    `PRME_ASSERT_IMP(a_count_nonzero, out_valid_reg, out_count_reg != 9'd0,
        "result beat with zero repeat count")
    `PRME_ASSERT_NXT(a_restart, emit && (step_reg == ST_EXIT2_CODE),
        (step_reg == ST_ESC) && out_last_reg, "move did not close with last beat")
    `PRME_ASSERT_IMP(a_pop_on_last, pop, emit && (step_next == ST_ESC),
        "move released before its final beat")

endmodule

// ----- hw/rtl/plotter_relative_move_encoder.sv -----
// A target passes the three front stages and the move queue before its first beat reaches the result port.
// Throughput: one result beat per cycle while the result port is ready; a move gives 8 to 14 beats,
// walked by the back-end step sequencer one byte per cycle.
// Targets are accepted every cycle while the four-entry move queue has room.
// A target equal to the pen position is taken but gives no beats.
// Reset: pen at (0,0), registers at their defaults, queue and result port empty.
// ----------------------------------------------------------------------------
// plotter_relative_move_encoder
// Encodes relative pen-up moves as terminal plot-mode byte runs.
// ----------------------------------------------------------------------------
module plotter_relative_move_encoder
    import prme_pkg::*;
#(
    parameter int COORD_BITS = 12,
    parameter int STEP_UNITS = 7
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Configuration write port
    input  logic                                  cfg_we,
    input  logic [1:0]                            cfg_index,
    input  logic [7:0]                            cfg_wdata,
    // Target beats
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata,  // target_x, target_y
    // Result beats
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [23:0]                           m_axis_tdata,  // out_byte, repeat_count
    output logic                                  m_axis_tlast   // last
);

    cfg_t       cfg_reg;
    move_t      push_data;
    move_t      head;
    logic       push;
    logic       pop;
    logic       q_empty;
    logic       q_full;
    logic [7:0] out_byte;
    logic [8:0] out_count;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pen_up_bits     <= RST_PEN_UP;
            cfg_reg.escape_byte     <= RST_ESCAPE;
            cfg_reg.enter_plot_byte <= RST_ENTER;
            cfg_reg.exit_plot_byte  <= RST_EXIT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_PEN_UP: cfg_reg.pen_up_bits     <= cfg_wdata;
                CFG_ESCAPE: cfg_reg.escape_byte     <= cfg_wdata;
                CFG_ENTER:  cfg_reg.enter_plot_byte <= cfg_wdata;
                CFG_EXIT:   cfg_reg.exit_plot_byte  <= cfg_wdata;
                default:    cfg_reg.pen_up_bits     <= cfg_reg.pen_up_bits;
            endcase
        end
    end

    prme_front #(
        .COORD_BITS (COORD_BITS),
        .STEP_UNITS (STEP_UNITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .target_x (s_axis_tdata[COORD_BITS-1:0]),
        .target_y (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
        .q_full   (q_full),
        .push     (push),
        .entry    (push_data)
    );

    prme_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    prme_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .head      (head),
        .empty     (q_empty),
        .pop       (pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_byte  (out_byte),
        .out_count (out_count),
        .out_last  (m_axis_tlast)
    );

    // Pack the result beat, byte in the low bits
    assign m_axis_tdata = {7'd0, out_count, out_byte};

endmodule
